@@ rtl/mbsp_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared constants, result kind codes and the result record type.
// ----------------------------------------------------------------------------
package mbsp_pkg;

   // Default number of system exclusive bytes the buffer can hold.
   localparam int SYSEX_DEPTH_DEF = 32;

   // Width of the configuration register.
   localparam int LIMIT_W = 6;

   // Reset value of the system exclusive limit.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

   // Result kind codes.
   localparam logic [4:0] KIND_ABORTED    = 5'd0;
   localparam logic [4:0] KIND_UNEXPECTED = 5'd1;
   localparam logic [4:0] KIND_OVERFLOW   = 5'd2;
   localparam logic [4:0] KIND_NOTE_OFF   = 5'd3;
   localparam logic [4:0] KIND_NOTE_ON    = 5'd4;
   localparam logic [4:0] KIND_POLY       = 5'd5;
   localparam logic [4:0] KIND_CC         = 5'd6;
   localparam logic [4:0] KIND_PROGRAM    = 5'd7;
   localparam logic [4:0] KIND_CHAN_PRESS = 5'd8;
   localparam logic [4:0] KIND_PITCH_BEND = 5'd9;
   localparam logic [4:0] KIND_CLOCK      = 5'd10;
   localparam logic [4:0] KIND_START      = 5'd11;
   localparam logic [4:0] KIND_CONTINUE   = 5'd12;
   localparam logic [4:0] KIND_STOP       = 5'd13;
   localparam logic [4:0] KIND_SENSING    = 5'd14;
   localparam logic [4:0] KIND_RESET      = 5'd15;
   localparam logic [4:0] KIND_SYSEX_BYTE = 5'd16;
   localparam logic [4:0] KIND_MTC        = 5'd17;
   localparam logic [4:0] KIND_SPP        = 5'd18;
   localparam logic [4:0] KIND_SONG       = 5'd19;
   localparam logic [4:0] KIND_TUNE       = 5'd20;

   // One result record, without the last mark.
   typedef struct packed {
      logic [4:0]  kind;
      logic [3:0]  channel;
      logic [6:0]  first_value;
      logic [6:0]  second_value;
      logic [13:0] wide_value;
      logic [7:0]  sysex_byte;
   } result_type;

   // Realtime byte low bits to result kind; undefined codes report no result.
   function automatic logic [4:0] rt_kind(input logic [2:0] code);
      logic [4:0] k;
      begin
         unique case (code)
            3'd0:    k = KIND_CLOCK;
            3'd2:    k = KIND_START;
            3'd3:    k = KIND_CONTINUE;
            3'd4:    k = KIND_STOP;
            3'd6:    k = KIND_SENSING;
            3'd7:    k = KIND_RESET;
            default: k = KIND_ABORTED;
         endcase
         return k;
      end
   endfunction

endpackage

@@ rtl/mbsp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/midi_byte_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Decodes a MIDI byte stream into channel, system and realtime messages.
// ----------------------------------------------------------------------------
// Usage: one MIDI byte enters per req_ transaction and produces zero or more
// rsp_ transactions; rsp_last marks the final result caused by that byte.
// Channel messages follow running status. Realtime bytes report at once and
// leave the parse alone. System exclusive bytes are collected in an on-chip
// RAM and played back, one rsp_ transaction per byte, when F7 ends the
// message (or an F0 ends a stale one).
// Timing: a byte is taken into the decode register, then a small sequencer
// works on it; req_stall is high until the byte is fully handled. A byte
// that makes at most one result is handled in S_DECODE, and one on the system
// exclusive path passes through S_TAKE as well. A dump reads each buffered
// byte from the registered RAM in S_DUMP_RD and reports it in S_DUMP_EMIT.
// Results wait in an output register; while rsp_stall is high the sequencer
// holds its next result, and req_stall stays high.
// Reset clears the parse state, the buffer count and the overflow flag, and
// sets the system exclusive limit to 32. The csr_ register may be written
// whenever the block is idle.
module midi_byte_stream_parser_unit #(
   parameter int SYSEX_DEPTH = mbsp_pkg::SYSEX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_kind,
   output logic [3:0]  rsp_channel,
   output logic [6:0]  rsp_first_value,
   output logic [6:0]  rsp_second_value,
   output logic [13:0] rsp_wide_value,
   output logic [7:0]  rsp_sysex_byte,
   output logic        rsp_last,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);
   import mbsp_pkg::*;

   localparam int AW = $clog2(SYSEX_DEPTH);
   localparam int CW = $clog2(SYSEX_DEPTH + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   // Byte values with a special meaning.
   localparam logic [7:0] BYTE_SOX = 8'hF0;
   localparam logic [7:0] BYTE_EOX = 8'hF7;

   // Sequencer states.
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_TAKE      = 3'd2;
   localparam logic [2:0] S_DUMP_RD   = 3'd3;
   localparam logic [2:0] S_DUMP_EMIT = 3'd4;

   // Parse phases.
   localparam logic [4:0] PH_WAIT  = 5'd0;
   localparam logic [4:0] PH_UNEXP = 5'd1;
   localparam logic [4:0] PH_OFF1  = 5'd2;
   localparam logic [4:0] PH_OFF2  = 5'd3;
   localparam logic [4:0] PH_ON1   = 5'd4;
   localparam logic [4:0] PH_ON2   = 5'd5;
   localparam logic [4:0] PH_POLY1 = 5'd6;
   localparam logic [4:0] PH_POLY2 = 5'd7;
   localparam logic [4:0] PH_CC1   = 5'd8;
   localparam logic [4:0] PH_CC2   = 5'd9;
   localparam logic [4:0] PH_PROG  = 5'd10;
   localparam logic [4:0] PH_CHP   = 5'd11;
   localparam logic [4:0] PH_PB1   = 5'd12;
   localparam logic [4:0] PH_PB2   = 5'd13;
   localparam logic [4:0] PH_SYSEX = 5'd14;
   localparam logic [4:0] PH_MTC   = 5'd15;
   localparam logic [4:0] PH_SPP1  = 5'd16;
   localparam logic [4:0] PH_SPP2  = 5'd17;
   localparam logic [4:0] PH_SONG  = 5'd18;

   // Registers and next values.
   logic [2:0]         state_ff, state_in;
   logic [4:0]         phase_ff, phase_in;
   logic [3:0]         held_channel_ff, held_channel_in;
   logic [6:0]         held_data_ff, held_data_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               pend_sox_ff, pend_sox_in;
   logic [7:0]         take_byte_ff, take_byte_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [7:0]         byte_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_res_ff, rsp_res_in;
   logic               rsp_last_ff, rsp_last_in;

   // Internal signals.
   logic          in_take;
   logic          out_free;
   logic [LW-1:0] lim_eff;
   logic          full;
   logic          tail_ovf;
   logic          dump_last;
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [7:0]    ram_rd_data;

   assign in_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Limit clipped to the buffer depth, and the buffer-full compare.
   always_comb begin
      if (LW'(limit_ff) > LW'(SYSEX_DEPTH)) begin
         lim_eff = LW'(SYSEX_DEPTH);
      end else begin
         lim_eff = LW'(limit_ff);
      end
   end
   assign full = LW'(count_ff) >= lim_eff;

   // A pending F0 after a stale flush overflows at once when the limit is zero.
   assign tail_ovf  = pend_sox_ff && (lim_eff == LW'(0));
   assign dump_last = (CW'(idx_ff) + CW'(1)) == count_ff;

   // Main sequencer.
   always_comb begin
      result_type res;
      logic       chan_status;
      res = '0;
      chan_status = 1'b0;

      state_in        = state_ff;
      phase_in        = phase_ff;
      held_channel_in = held_channel_ff;
      held_data_in    = held_data_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      pend_sox_in     = pend_sox_ff;
      take_byte_in    = take_byte_ff;
      idx_in          = idx_ff;
      rsp_res_in      = rsp_res_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (in_take) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            if (byte_ff[7:3] == 5'b11111) begin
               // Realtime: report only, parse state untouched.
               res.kind = rt_kind(byte_ff[2:0]);
               if (res.kind != KIND_ABORTED) begin
                  if (out_free) begin
                     rsp_res_in   = res;
                     rsp_last_in  = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end else if (byte_ff[7:4] == 4'hF) begin
               // System common.
               unique case (byte_ff[3:0])
                  4'h0: begin
                     if (count_ff != '0) begin
                        take_byte_in = BYTE_EOX;
                        pend_sox_in  = 1'b1;
                     end else begin
                        take_byte_in = BYTE_SOX;
                        ovf_in       = 1'b0;
                        phase_in     = PH_SYSEX;
                     end
                     state_in = S_TAKE;
                  end
                  4'h7: begin
                     take_byte_in = BYTE_EOX;
                     state_in     = S_TAKE;
                  end
                  4'h1: begin
                     phase_in = PH_MTC;
                     state_in = S_IDLE;
                  end
                  4'h2: begin
                     phase_in = PH_SPP1;
                     state_in = S_IDLE;
                  end
                  4'h3: begin
                     phase_in = PH_SONG;
                     state_in = S_IDLE;
                  end
                  4'h6: begin
                     if (out_free) begin
                        res.kind     = KIND_TUNE;
                        rsp_res_in   = res;
                        rsp_last_in  = 1'b1;
                        rsp_valid_in = 1'b1;
                        phase_in     = PH_UNEXP;
                        state_in     = S_IDLE;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end else if (byte_ff[7]) begin
               // Channel status: set up running status.
               held_channel_in = byte_ff[3:0];
               unique case (byte_ff[6:4])
                  3'd0:    phase_in = PH_OFF1;
                  3'd1:    phase_in = PH_ON1;
                  3'd2:    phase_in = PH_POLY1;
                  3'd3:    phase_in = PH_CC1;
                  3'd4:    phase_in = PH_PROG;
                  3'd5:    phase_in = PH_CHP;
                  default: phase_in = PH_PB1;
               endcase
               state_in = S_IDLE;
            end else if (phase_ff == PH_SYSEX) begin
               take_byte_in = byte_ff;
               state_in     = S_TAKE;
            end else begin
               // Data byte in a message phase.
               res.channel = held_channel_ff;
               case (phase_ff) inside
                  PH_OFF1, PH_ON1, PH_POLY1, PH_CC1, PH_PB1, PH_SPP1: begin
                     held_data_in = byte_ff[6:0];
                     phase_in     = phase_ff + 5'd1;
                     state_in     = S_IDLE;
                  end
                  PH_OFF2, PH_ON2, PH_POLY2, PH_CC2: begin
                     chan_status      = 1'b1;
                     res.first_value  = held_data_ff;
                     res.second_value = byte_ff[6:0];
                     case (phase_ff)
                        PH_OFF2: res.kind = KIND_NOTE_OFF;
                        PH_ON2:  res.kind = KIND_NOTE_ON;
                        PH_POLY2: res.kind = KIND_POLY;
                        default: res.kind = KIND_CC;
                     endcase
                  end
                  PH_PROG, PH_CHP: begin
                     chan_status     = 1'b1;
                     res.first_value = byte_ff[6:0];
                     res.kind = (phase_ff == PH_PROG) ? KIND_PROGRAM : KIND_CHAN_PRESS;
                  end
                  PH_PB2: begin
                     chan_status    = 1'b1;
                     res.kind       = KIND_PITCH_BEND;
                     res.wide_value = {byte_ff[6:0], held_data_ff};
                  end
                  PH_MTC: begin
                     res.kind         = KIND_MTC;
                     res.first_value  = {3'd0, byte_ff[3:0]};
                     res.second_value = {4'd0, byte_ff[6:4]};
                  end
                  PH_SPP2: begin
                     res.kind       = KIND_SPP;
                     res.wide_value = {byte_ff[6:0], held_data_ff};
                  end
                  PH_SONG: begin
                     res.kind        = KIND_SONG;
                     res.first_value = byte_ff[6:0];
                  end
                  PH_WAIT: res.kind = KIND_ABORTED;
                  default: res.kind = KIND_UNEXPECTED;
               endcase
               if (!chan_status) begin
                  res.channel = 4'd0;
               end
               // Everything but the first data byte of a two-data-byte message reports.
               if (state_in == S_DECODE && out_free) begin
                  rsp_res_in   = res;
                  rsp_last_in  = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  case (phase_ff) inside
                     PH_OFF2, PH_ON2, PH_POLY2, PH_CC2, PH_PB2: begin
                        phase_in = phase_ff - 5'd1;
                     end
                     PH_MTC, PH_SPP2, PH_SONG: begin
                        phase_in = PH_UNEXP;
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         end

         S_TAKE: begin
            // One byte into the buffer, or, when full, one overflow report per message.
            if (!(full && !ovf_ff) || out_free) begin
               if (full) begin
                  if (!ovf_ff) begin
                     res.kind     = KIND_OVERFLOW;
                     rsp_res_in   = res;
                     rsp_last_in  = !tail_ovf;
                     rsp_valid_in = 1'b1;
                  end
                  ovf_in = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
               state_in = S_IDLE;
               if (take_byte_ff == BYTE_EOX) begin
                  phase_in = PH_UNEXP;
                  if (!(ovf_ff || full)) begin
                     idx_in   = '0;
                     state_in = S_DUMP_RD;
                  end else begin
                     count_in = '0;
                  end
               end
               // Start the new message after a stale flush.
               if (state_in == S_IDLE && pend_sox_ff) begin
                  pend_sox_in  = 1'b0;
                  ovf_in       = 1'b0;
                  count_in     = '0;
                  phase_in     = PH_SYSEX;
                  take_byte_in = BYTE_SOX;
                  state_in     = S_TAKE;
               end
            end
         end

         S_DUMP_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_DUMP_EMIT;
         end

         S_DUMP_EMIT: begin
            if (out_free) begin
               res.kind       = KIND_SYSEX_BYTE;
               res.sysex_byte = ram_rd_data;
               rsp_res_in     = res;
               rsp_last_in    = dump_last && !tail_ovf;
               rsp_valid_in   = 1'b1;
               if (dump_last) begin
                  count_in = '0;
                  state_in = S_IDLE;
                  if (pend_sox_ff) begin
                     pend_sox_in  = 1'b0;
                     ovf_in       = 1'b0;
                     phase_in     = PH_SYSEX;
                     take_byte_in = BYTE_SOX;
                     state_in     = S_TAKE;
                  end
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         phase_ff        <= PH_WAIT;
         held_channel_ff <= '0;
         held_data_ff    <= '0;
         count_ff        <= '0;
         ovf_ff          <= 1'b0;
         pend_sox_ff     <= 1'b0;
         limit_ff        <= LIMIT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         held_channel_ff <= held_channel_in;
         held_data_ff    <= held_data_in;
         count_ff        <= count_in;
         ovf_ff          <= ovf_in;
         pend_sox_ff     <= pend_sox_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_take) begin
         byte_ff <= req_data_byte;
      end
      take_byte_ff <= take_byte_in;
      idx_ff       <= idx_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // System exclusive buffer.
   mbsp_ram #(
      .WIDTH (8),
      .DEPTH (SYSEX_DEPTH)
   ) u_sysex_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (take_byte_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // Result ports.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_res_ff.kind;
   assign rsp_channel      = rsp_res_ff.channel;
   assign rsp_first_value  = rsp_res_ff.first_value;
   assign rsp_second_value = rsp_res_ff.second_value;
   assign rsp_wide_value   = rsp_res_ff.wide_value;
   assign rsp_sysex_byte   = rsp_res_ff.sysex_byte;
   assign rsp_last         = rsp_last_ff;

endmodule

@@ rtl/mbsp_checker.sv @@
// ----------------------------------------------------------------------------
// MIDI byte stream parser checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mbsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_kind,
   input logic [7:0]  rsp_sysex_byte,
   input logic        rsp_last
);
   import mbsp_pkg::*;

   // An accepted byte is worked on before the next one is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a byte was still being worked on");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only buffer bytes and overflow reports can be followed by more results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SYSEX_BYTE && rsp_kind != KIND_OVERFLOW |-> rsp_last)
      else $error("single-result message without last mark");

   // Result kinds stay in the defined range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= KIND_TUNE)
      else $error("undefined result kind");

   // The buffer byte field is only used by dump results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SYSEX_BYTE |-> rsp_sysex_byte == 8'd0)
      else $error("buffer byte field set on a non-dump result");

   // The result stall is not examined by any assertion here.
   wire unused_stall = rsp_stall;

endmodule

bind midi_byte_stream_parser_unit mbsp_checker u_mbsp_checker (.*);

@@ tb/midi_byte_stream_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Feeds MIDI bytes through the request channel and checks every result
// against a behavioral predictor of the parser. A short directed opening
// covers running status, stray data, undefined statuses and the system
// exclusive corner cases; random message streams follow under several
// buffer limits, with random idling on the request channel and stalling on the result channel.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit_tb;
   import mbsp_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 90;
   localparam int SETTLE_CYCLES    = 8;
   localparam int END_CYCLES       = 24;
   localparam int PHASE_ITEMS      = 12;
   localparam int STORE_DEPTH      = SYSEX_DEPTH_DEF;

   // Status bytes, channel statuses with the channel nibble clear.
   localparam logic [7:0] CH_NOTE_OFF  = 8'h80;
   localparam logic [7:0] CH_NOTE_ON   = 8'h90;
   localparam logic [7:0] CH_POLY      = 8'hA0;
   localparam logic [7:0] CH_CTRL      = 8'hB0;
   localparam logic [7:0] CH_PROG      = 8'hC0;
   localparam logic [7:0] CH_PRESS     = 8'hD0;
   localparam logic [7:0] CH_BEND      = 8'hE0;
   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] MTC_STATUS   = 8'hF1;
   localparam logic [7:0] SPP_STATUS   = 8'hF2;
   localparam logic [7:0] SONG_STATUS  = 8'hF3;
   localparam logic [7:0] SC_UNDEF_F4  = 8'hF4;
   localparam logic [7:0] SC_UNDEF_F5  = 8'hF5;
   localparam logic [7:0] TUNE_STATUS  = 8'hF6;
   localparam logic [7:0] SYSEX_END    = 8'hF7;
   localparam logic [7:0] RT_CLOCK     = 8'hF8;
   localparam logic [7:0] RT_UNDEF_F9  = 8'hF9;
   localparam logic [7:0] RT_START     = 8'hFA;
   localparam logic [7:0] RT_CONTINUE  = 8'hFB;
   localparam logic [7:0] RT_STOP      = 8'hFC;
   localparam logic [7:0] RT_UNDEF_FD  = 8'hFD;
   localparam logic [7:0] RT_SENSING   = 8'hFE;
   localparam logic [7:0] RT_RESET     = 8'hFF;

   // Where the decoder stands between bytes.
   typedef enum logic [4:0] {
      AWAIT_STATUS, AFTER_COMMON,
      OFF_KEY, OFF_VEL, ON_KEY, ON_VEL, POLY_KEY, POLY_VAL,
      CTRL_NUM, CTRL_VAL, PROG_NUM, PRESS_VAL, BEND_LSB, BEND_MSB,
      IN_SYSEX, MTC_PIECE, SPP_LSB, SPP_MSB, SONG_NUM
   } parse_state_type;

   typedef struct packed {
      result_type fields;
      logic       last;
   } midi_event_type;

   // Predicts the decoded messages and checks them in order.
   class midi_scoreboard;
      parse_state_type state;
      logic [3:0]      chan_hold;
      logic [6:0]      data_hold;
      logic [7:0]      sysex_mem [STORE_DEPTH];
      int unsigned     sysex_fill;
      bit              sysex_over;
      logic [5:0]      sysex_limit;
      midi_event_type  expected_q [$];
      midi_event_type  step_q [$];
      int              errors;

      function new();
         state       = AWAIT_STATUS;
         chan_hold   = '0;
         data_hold   = '0;
         sysex_fill  = 0;
         sysex_over  = 1'b0;
         sysex_limit = LIMIT_RESET;
         errors      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void emit(logic [4:0] k, logic [3:0] ch, logic [6:0] a, logic [6:0] b,
                         logic [13:0] w, logic [7:0] sx);
         midi_event_type ev;
         ev.fields.kind         = k;
         ev.fields.channel      = ch;
         ev.fields.first_value  = a;
         ev.fields.second_value = b;
         ev.fields.wide_value   = w;
         ev.fields.sysex_byte   = sx;
         ev.last                = 1'b0;
         step_q.push_back(ev);
      endfunction

      // System exclusive collection; an F0 first closes a stale message.
      function void absorb_sysex(logic [7:0] b);
         int unsigned room = (sysex_limit > STORE_DEPTH) ? STORE_DEPTH : sysex_limit;
         if (b == SYSEX_START) begin
            if (sysex_fill != 0)
               absorb_sysex(SYSEX_END);
            sysex_over = 1'b0;
            sysex_fill = 0;
            state      = IN_SYSEX;
         end
         if (sysex_fill >= room) begin
            if (!sysex_over) begin
               emit(KIND_OVERFLOW, 0, 0, 0, 0, 0);
               sysex_over = 1'b1;
            end
         end else begin
            sysex_mem[sysex_fill] = b;
            sysex_fill++;
         end
         if (b == SYSEX_END) begin
            if (!sysex_over)
               for (int i = 0; i < sysex_fill; i++)
                  emit(KIND_SYSEX_BYTE, 0, 0, 0, 0, sysex_mem[i]);
            sysex_fill = 0;
            state      = AFTER_COMMON;
         end
      endfunction

      // Data bytes advance, complete or repeat the message in progress, or report as stray.
      function void take_data(logic [6:0] d);
         case (state)
            OFF_KEY:   begin data_hold = d; state = OFF_VEL; end
            OFF_VEL:   begin emit(KIND_NOTE_OFF, chan_hold, data_hold, d, 0, 0); state = OFF_KEY; end
            ON_KEY:    begin data_hold = d; state = ON_VEL; end
            ON_VEL:    begin emit(KIND_NOTE_ON, chan_hold, data_hold, d, 0, 0); state = ON_KEY; end
            POLY_KEY:  begin data_hold = d; state = POLY_VAL; end
            POLY_VAL:  begin emit(KIND_POLY, chan_hold, data_hold, d, 0, 0); state = POLY_KEY; end
            CTRL_NUM:  begin data_hold = d; state = CTRL_VAL; end
            CTRL_VAL:  begin emit(KIND_CC, chan_hold, data_hold, d, 0, 0); state = CTRL_NUM; end
            PROG_NUM:  emit(KIND_PROGRAM, chan_hold, d, 0, 0, 0);
            PRESS_VAL: emit(KIND_CHAN_PRESS, chan_hold, d, 0, 0, 0);
            BEND_LSB:  begin data_hold = d; state = BEND_MSB; end
            BEND_MSB:  begin
               emit(KIND_PITCH_BEND, chan_hold, 0, 0, {d, data_hold}, 0);
               state = BEND_LSB;
            end
            IN_SYSEX:  absorb_sysex({1'b0, d});
            MTC_PIECE: begin
               emit(KIND_MTC, 0, {3'b000, d[3:0]}, {4'b0000, d[6:4]}, 0, 0);
               state = AFTER_COMMON;
            end
            SPP_LSB:   begin data_hold = d; state = SPP_MSB; end
            SPP_MSB:   begin
               emit(KIND_SPP, 0, 0, 0, {d, data_hold}, 0);
               state = AFTER_COMMON;
            end
            SONG_NUM:  begin emit(KIND_SONG, 0, d, 0, 0, 0); state = AFTER_COMMON; end
            AWAIT_STATUS: emit(KIND_ABORTED, 0, 0, 0, 0, 0);
            default:   emit(KIND_UNEXPECTED, 0, 0, 0, 0, 0);
         endcase
      endfunction

      // Works out the results of one accepted input transaction.
      function void note_byte(logic [7:0] b);
         step_q.delete();
         if (b >= RT_CLOCK) begin
            case (b)
               RT_CLOCK:    emit(KIND_CLOCK, 0, 0, 0, 0, 0);
               RT_START:    emit(KIND_START, 0, 0, 0, 0, 0);
               RT_CONTINUE: emit(KIND_CONTINUE, 0, 0, 0, 0, 0);
               RT_STOP:     emit(KIND_STOP, 0, 0, 0, 0, 0);
               RT_SENSING:  emit(KIND_SENSING, 0, 0, 0, 0, 0);
               RT_RESET:    emit(KIND_RESET, 0, 0, 0, 0, 0);
               default:     ;
            endcase
         end else if (b >= SYSEX_START) begin
            case (b)
               SYSEX_START, SYSEX_END: absorb_sysex(b);
               MTC_STATUS:  state = MTC_PIECE;
               SPP_STATUS:  state = SPP_LSB;
               SONG_STATUS: state = SONG_NUM;
               TUNE_STATUS: begin
                  emit(KIND_TUNE, 0, 0, 0, 0, 0);
                  state = AFTER_COMMON;
               end
               default:     ;
            endcase
         end else if (b[7]) begin
            chan_hold = b[3:0];
            case ({b[7:4], 4'h0})
               CH_NOTE_OFF: state = OFF_KEY;
               CH_NOTE_ON:  state = ON_KEY;
               CH_POLY:     state = POLY_KEY;
               CH_CTRL:     state = CTRL_NUM;
               CH_PROG:     state = PROG_NUM;
               CH_PRESS:    state = PRESS_VAL;
               default:     state = BEND_LSB;
            endcase
         end else begin
            take_data(b[6:0]);
         end
         if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
         foreach (step_q[i])
            expected_q.push_back(step_q[i]);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, logic [13:0] got, logic [13:0] want);
         if (got !== want)
            report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      endtask

      // Compares one accepted result transaction with the oldest expectation.
      task check_result(result_type got, logic got_last);
         midi_event_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result of kind %0d with nothing expected", got.kind));
            return;
         end
         want = expected_q.pop_front();
         compare_field("kind", 14'(got.kind), 14'(want.fields.kind));
         compare_field("channel", 14'(got.channel), 14'(want.fields.channel));
         compare_field("first_value", 14'(got.first_value), 14'(want.fields.first_value));
         compare_field("second_value", 14'(got.second_value),
                       14'(want.fields.second_value));
         compare_field("wide_value", got.wide_value, want.fields.wide_value);
         compare_field("sysex_byte", 14'(got.sysex_byte), 14'(want.fields.sysex_byte));
         compare_field("last", 14'(got_last), 14'(want.last));
      endtask
   endclass

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [4:0]  rsp_kind;
   logic [3:0]  rsp_channel;
   logic [6:0]  rsp_first_value;
   logic [6:0]  rsp_second_value;
   logic [13:0] rsp_wide_value;
   logic [7:0]  rsp_sysex_byte;
   logic        rsp_last;
   logic        csr_wr_en     = 1'b0;
   logic [5:0]  csr_wr_data   = '0;

   midi_scoreboard sb;
   bit             idle_on       = 1'b1;
   int             items_sent    = 0;
   int             hold_requests = 0;
   int             holds_done    = 0;
   int             hold_left     = 0;
   int             burst_left    = 0;
   logic [7:0]     opening_seq [$];
   logic [7:0]     overflow_seq [$];

   midi_byte_stream_parser_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_channel      (rsp_channel),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_wide_value   (rsp_wide_value),
      .rsp_sysex_byte   (rsp_sysex_byte),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Result side: check each accepted transaction, then pick the next stall.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result({rsp_kind, rsp_channel, rsp_first_value, rsp_second_value,
                          rsp_wide_value, rsp_sysex_byte}, rsp_last);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left  = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("** midi_byte_stream_parser_unit: FAILED **");
      $finish;
   end

   // Offers one byte, with an occasional idle burst first, and waits for it.
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_byte(b);
      if (b != SC_UNDEF_F4 && b != SC_UNDEF_F5 && b != RT_UNDEF_F9 && b != RT_UNDEF_FD)
         items_sent++;
   endtask

   // Stops offering until every expected result is in, then idles a while.
   task automatic drain(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_limit(input logic [5:0] value);
      drain(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.sysex_limit = value;
   endtask

   function automatic logic [7:0] rand_data();
      int unsigned pick = $urandom_range(0, 9);
      if (pick == 0)
         return 8'h00;
      if (pick == 1)
         return 8'h7F;
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic logic [7:0] rand_status();
      return 8'($urandom_range(CH_NOTE_OFF, CH_BEND | 8'h0F));
   endfunction

   // One random message: mostly well formed, with stray bytes mixed in.
   task automatic send_random_message();
      int unsigned pick;
      int unsigned n;
      int unsigned room;
      logic [7:0]  st;
      pick = $urandom_range(0, 99);
      room = (sb.sysex_limit > STORE_DEPTH) ? STORE_DEPTH : sb.sysex_limit;
      if (pick < 40) begin
         // Channel message, repeated under running status.
         st = rand_status();
         send_byte(st);
         repeat ($urandom_range(1, 3)) begin
            send_byte(rand_data());
            if ($urandom_range(0, 5) == 0)
               send_byte(8'($urandom_range(RT_CLOCK, RT_RESET)));
            if ({st[7:4], 4'h0} != CH_PROG && {st[7:4], 4'h0} != CH_PRESS)
               send_byte(rand_data());
         end
      end else if (pick < 52) begin
         send_byte(8'($urandom_range(RT_CLOCK, RT_RESET)));
      end else if (pick < 64) begin
         case ($urandom_range(0, 3))
            0: begin
               send_byte(MTC_STATUS);
               send_byte(rand_data());
            end
            1: begin
               send_byte(SPP_STATUS);
               send_byte(rand_data());
               send_byte(rand_data());
            end
            2: begin
               send_byte(SONG_STATUS);
               send_byte(rand_data());
            end
            default: send_byte(TUNE_STATUS);
         endcase
         if ($urandom_range(0, 3) == 0)
            send_byte(rand_data());
      end else if (pick < 86) begin
         // System exclusive, mostly short, sometimes up to past the limit.
         send_byte(SYSEX_START);
         if ($urandom_range(0, 5) == 0)
            n = $urandom_range(0, room + 1);
         else
            n = $urandom_range(0, 6);
         repeat (n) send_byte(rand_data());
         case ($urandom_range(0, 7))
            0:       ;
            1:       send_byte(rand_status());
            default: send_byte(SYSEX_END);
         endcase
      end else begin
         send_byte(8'($urandom));
      end
   endtask

   initial begin : stimulus
      logic [5:0] limit_plan [6];
      int         stop_at;
      sb = new();
      limit_plan   = '{6'd5, 6'd1, 6'd0, 6'd63, 6'd17, 6'd32};
      opening_seq  = '{8'h00, CH_NOTE_ON | 8'h0F, 8'h7F, 8'h00, 8'h01, 8'h7F,
                       CH_PRESS, 8'h55, 8'h2A, CH_BEND | 8'h03, 8'h7F, RT_CLOCK, 8'h7F,
                       SONG_STATUS, 8'h7F, 8'h00, SC_UNDEF_F4, RT_UNDEF_FD, 8'h01,
                       SYSEX_START, 8'h11, CH_CTRL | 8'h02, 8'h07, 8'h64,
                       SYSEX_START, SYSEX_END, SYSEX_END};
      overflow_seq = '{SYSEX_START, 8'h01, 8'h02, 8'h03, SYSEX_END, SYSEX_END,
                       TUNE_STATUS, 8'h40};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset limit, then overflow on a tiny buffer.
      foreach (opening_seq[i])
         send_byte(opening_seq[i]);
      write_limit(6'd2);
      foreach (overflow_seq[i])
         send_byte(overflow_seq[i]);

      // Random phases, one buffer limit each.
      for (int p = 0; p < 6; p++) begin
         write_limit(limit_plan[p]);
         if (p == 5)
            idle_on = 1'b0;
         if (p == 1)
            hold_requests++;
         if (limit_plan[p] > STORE_DEPTH) begin
            // A full buffer overflows on the closing byte; one less dumps it all.
            for (int n = STORE_DEPTH - 1; n >= STORE_DEPTH - 2; n--) begin
               send_byte(SYSEX_START);
               repeat (n) send_byte(rand_data());
               send_byte(SYSEX_END);
            end
         end
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at)
            send_random_message();
         if (p == 2)
            drain(0);
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at)
            send_random_message();
      end

      drain(END_CYCLES);
      if (sb.errors == 0)
         $display("** midi_byte_stream_parser_unit: PASSED **");
      else
         $display("** midi_byte_stream_parser_unit: FAILED **");
      $finish;
   end

endmodule
